[rtl/wsg_pkg.sv]
// Shared types, constants and the coefficient table of the waveform sample generator.
package wsg_pkg;

    localparam int DEGREE_DEF     = 19;
    localparam int PHASE_BITS_DEF = 16;

    localparam int MODE_W   = 2;
    localparam int SAMPLE_W = 8;
    localparam int Q_W      = 64;
    localparam int X_W      = 59;
    localparam int XHI_W    = X_W - 32;

    localparam logic [MODE_W-1:0] MODE_SQUARE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAWTOOTH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRIANGLE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SINE     = 2'd3;

    // Two pi in Q3.56, split into the low 32 bits and the rest.
    localparam logic [31:0]      TWO_PI_LO = 32'h110B_4612;
    localparam logic [XHI_W-1:0] TWO_PI_HI = 27'h648_7ED5;

    localparam logic [Q_W-1:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 64'h8000_0000_0000_0000;

    // 127 + 0.5 in Q56 units.
    localparam logic [Q_W-1:0] ROUND_BIAS = 64'h7F80_0000_0000_0000;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [SAMPLE_W-1:0] simple;
        logic [X_W-1:0]      x;
    } t_side;

    typedef struct packed {
        logic           vld;
        t_side          side;
        logic [Q_W-1:0] r;
    } t_cell_bus;

    // Magnitude of the Taylor coefficient 1/k! in Q56, floored step by step.
    function automatic logic [Q_W-1:0] coef_mag(input int k);
        logic [Q_W-1:0] m;
        case (k)
            1:       m = 64'd72057594037927936;
            2:       m = 64'd36028797018963968;
            3:       m = 64'd12009599006321322;
            4:       m = 64'd3002399751580330;
            5:       m = 64'd600479950316066;
            6:       m = 64'd100079991719344;
            7:       m = 64'd14297141674192;
            8:       m = 64'd1787142709274;
            9:       m = 64'd198571412141;
            10:      m = 64'd19857141214;
            11:      m = 64'd1805194655;
            12:      m = 64'd150432887;
            13:      m = 64'd11571760;
            14:      m = 64'd826554;
            15:      m = 64'd55103;
            16:      m = 64'd3443;
            17:      m = 64'd202;
            18:      m = 64'd11;
            default: m = 64'd0;
        endcase
        return m;
    endfunction

endpackage

[rtl/wsg_phase_if.sv]
// Stream channel that carries one phase value per beat.
interface wsg_phase_if #(
    parameter int PHASE_BITS = wsg_pkg::PHASE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PHASE_BITS-1:0] phase;

    modport source (output valid, output phase, input ready);
    modport sink (input valid, input phase, output ready);
endinterface

[rtl/wsg_sample_if.sv]
// Stream channel that carries one 8-bit sample per beat.
interface wsg_sample_if;
    logic                          valid;
    logic                          ready;
    logic [wsg_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

[rtl/wsg_front.sv]
// Front stages: phase to Q3.56 angle and the square, sawtooth and triangle shapes.
module wsg_front #(
    parameter int PHASE_BITS = wsg_pkg::PHASE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [PHASE_BITS-1:0]        i_phase,
    input  logic [wsg_pkg::MODE_W-1:0]   i_mode,
    output wsg_pkg::t_cell_bus           o_bus
);
    localparam int PL_W   = PHASE_BITS + 32;
    localparam int PH_W   = PHASE_BITS + wsg_pkg::XHI_W;
    localparam int FULL_W = PHASE_BITS + wsg_pkg::X_W;
    localparam logic [PHASE_BITS-1:0] HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};

    logic                          r_vld_a;
    logic [wsg_pkg::MODE_W-1:0]    r_mode_a;
    logic [PHASE_BITS-1:0]         r_p;
    logic [PL_W-1:0]               r_pl;
    logic [PH_W-1:0]               r_ph;
    logic                          r_vld_b;
    wsg_pkg::t_side                r_side;

    logic [PL_W-1:0]               n_pl;
    logic [PH_W-1:0]               n_ph;
    logic [FULL_W-1:0]             n_full;
    logic [PHASE_BITS+7:0]         n_saw;
    logic [PHASE_BITS:0]           n_neg;
    logic [PHASE_BITS-1:0]         n_q;
    logic [PHASE_BITS+8:0]         n_tri;
    logic [wsg_pkg::SAMPLE_W-1:0]  n_simple;

    assign n_pl   = PL_W'(i_phase) * PL_W'(wsg_pkg::TWO_PI_LO);
    assign n_ph   = PH_W'(i_phase) * PH_W'(wsg_pkg::TWO_PI_HI);
    assign n_full = {r_ph, 32'd0} + FULL_W'(r_pl);

    assign n_saw = {r_p, 8'd0} - (PHASE_BITS + 8)'(r_p) + (PHASE_BITS + 8)'(HALF);
    assign n_neg = {1'b1, {PHASE_BITS{1'b0}}} - {1'b0, r_p};
    assign n_q   = r_p[PHASE_BITS-1] ? n_neg[PHASE_BITS-1:0] : r_p;
    assign n_tri = {n_q, 9'd0} - (PHASE_BITS + 9)'({n_q, 1'b0})
                 + (PHASE_BITS + 9)'(HALF);

    always_comb begin
        case (r_mode_a)
            wsg_pkg::MODE_SQUARE:   n_simple = r_p[PHASE_BITS-1] ? 8'd0 : 8'd255;
            wsg_pkg::MODE_SAWTOOTH: n_simple = n_saw[PHASE_BITS +: 8];
            wsg_pkg::MODE_TRIANGLE: n_simple = n_tri[PHASE_BITS +: 8];
            default:                n_simple = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mode_a      <= i_mode;
            r_p           <= i_phase;
            r_pl          <= n_pl;
            r_ph          <= n_ph;
            r_side.mode   <= r_mode_a;
            r_side.simple <= n_simple;
            r_side.x      <= n_full[PHASE_BITS +: wsg_pkg::X_W];
        end
    end

    assign o_bus.vld  = r_vld_b;
    assign o_bus.side = r_side;
    assign o_bus.r    = '0;
endmodule

[rtl/wsg_cell.sv]
// One Horner cell: saturating coefficient add, then a split and saturated Q8.56 multiply.
module wsg_cell #(
    parameter int K = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  wsg_pkg::t_cell_bus i_bus,
    output wsg_pkg::t_cell_bus o_bus
);
    localparam logic [wsg_pkg::Q_W-1:0] COEF_MAG = wsg_pkg::coef_mag(K);
    localparam logic [wsg_pkg::Q_W-1:0] COEF =
        (K % 2 == 0) ? 64'd0 : ((K % 4 == 1) ? COEF_MAG : 64'd0 - COEF_MAG);

    logic [3:0]                  r_vld;
    wsg_pkg::t_side              r_side [0:3];
    logic [wsg_pkg::Q_W-1:0]     r_a;
    logic [63:0]                 r_pll;
    logic [58:0]                 r_plh;
    logic [64:0]                 r_phl;
    logic [59:0]                 r_phh;
    logic [91:0]                 r_t0;
    logic [92:0]                 r_t1;
    logic [wsg_pkg::Q_W-1:0]     r_r;

    logic [wsg_pkg::Q_W-1:0]     n_sum;
    logic                        n_ovf;
    logic [wsg_pkg::Q_W-1:0]     n_a;
    logic [31:0]                 n_a_lo;
    logic [31:0]                 n_a_hi;
    logic [31:0]                 n_x_lo;
    logic [wsg_pkg::XHI_W-1:0]   n_x_hi;
    logic [63:0]                 n_pll;
    logic [58:0]                 n_plh;
    logic signed [64:0]          n_phl;
    logic signed [59:0]          n_phh;
    logic [91:0]                 n_t0;
    logic [92:0]                 n_t1;
    logic [124:0]                n_prod;
    logic [wsg_pkg::Q_W-1:0]     n_r;

    assign n_sum = i_bus.r + COEF;
    assign n_ovf = (i_bus.r[63] == COEF[63]) && (n_sum[63] != i_bus.r[63]);
    assign n_a   = n_ovf ? (i_bus.r[63] ? wsg_pkg::Q_MIN : wsg_pkg::Q_MAX) : n_sum;

    assign n_a_lo = r_a[31:0];
    assign n_a_hi = r_a[63:32];
    assign n_x_lo = r_side[0].x[31:0];
    assign n_x_hi = r_side[0].x[wsg_pkg::X_W-1:32];
    assign n_pll  = 64'(n_a_lo) * 64'(n_x_lo);
    assign n_plh  = 59'(n_a_lo) * 59'(n_x_hi);
    assign n_phl  = $signed(n_a_hi) * $signed({1'b0, n_x_lo});
    assign n_phh  = $signed(n_a_hi) * $signed({1'b0, n_x_hi});

    assign n_t0 = {28'd0, r_pll} + {1'b0, r_plh, 32'd0};
    assign n_t1 = {{28{r_phl[64]}}, r_phl} + {r_phh[59], r_phh, 32'd0};

    assign n_prod = {r_t1, 32'd0} + {33'd0, r_t0};

    always_comb begin
        if ((n_prod[124:119] == 6'b000000) || (n_prod[124:119] == 6'b111111)) begin
            n_r = n_prod[119:56];
        end else begin
            n_r = n_prod[124] ? wsg_pkg::Q_MIN : wsg_pkg::Q_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 4'd0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_bus.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_bus.side;
            r_side[1] <= r_side[0];
            r_side[2] <= r_side[1];
            r_side[3] <= r_side[2];
            r_a       <= n_a;
            r_pll     <= n_pll;
            r_plh     <= n_plh;
            r_phl     <= n_phl;
            r_phh     <= n_phh;
            r_t0      <= n_t0;
            r_t1      <= n_t1;
            r_r       <= n_r;
        end
    end

    assign o_bus.vld  = r_vld[3];
    assign o_bus.side = r_side[3];
    assign o_bus.r    = r_r;
endmodule

[rtl/wsg_back.sv]
// Back stages: sine scaling and rounding, shape select and the output register.
module wsg_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  wsg_pkg::t_cell_bus            i_bus,
    output logic                          o_vld,
    output logic [wsg_pkg::SAMPLE_W-1:0]  o_sample
);
    logic                          r_vld_1;
    logic [wsg_pkg::MODE_W-1:0]    r_mode_1;
    logic [wsg_pkg::SAMPLE_W-1:0]  r_simple_1;
    logic [71:0]                   r_t;
    logic                          r_out_vld;
    logic [wsg_pkg::SAMPLE_W-1:0]  r_result;

    logic [71:0]                   n_t;
    logic [71:0]                   n_v;
    logic [wsg_pkg::SAMPLE_W-1:0]  n_sine;
    logic [wsg_pkg::SAMPLE_W-1:0]  n_result;

    assign n_t = {i_bus.r[63], i_bus.r, 7'd0} - {{8{i_bus.r[63]}}, i_bus.r};
    assign n_v = r_t + 72'(wsg_pkg::ROUND_BIAS);

    always_comb begin
        if (n_v[71]) begin
            n_sine = 8'd0;
        end else if (n_v[71:64] != 8'd0) begin
            n_sine = 8'd255;
        end else begin
            n_sine = n_v[63:56];
        end
    end

    assign n_result = (r_mode_1 == wsg_pkg::MODE_SINE) ? n_sine : r_simple_1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_1   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld_1   <= i_bus.vld;
            r_out_vld <= r_vld_1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mode_1   <= i_bus.side.mode;
            r_simple_1 <= i_bus.side.simple;
            r_t        <= n_t;
            r_result   <= n_result;
        end
    end

    assign o_vld    = r_out_vld;
    assign o_sample = r_result;
endmodule

[rtl/waveform_sample_generator.sv]
// Waveform sample generator: square, sawtooth, triangle or Taylor sine sample per phase.
//
// The i_phase channel takes one phase beat, a fraction of one period; the o_sample
// channel returns one 8-bit sample beat for each, in order. The shape comes from the
// wave_mode register, written through i_cfg_we and i_cfg_wdata: 0 square,
// 1 sawtooth, 2 triangle, 3 sine. The user must write it only while no beat is in flight.
// The block does not enforce this. The sine is a Horner evaluation run down a row of
// DEGREE cells, one cell per coefficient, each registering its saturating add, the
// partial products of its split 64-bit multiply, their sums and the saturated product.
// Every shape passes through that row, so every shape is delayed alike. Throughput is
// one beat per cycle while o_sample.ready does not stall the pipeline.
// When the receiver holds o_sample.ready low while a sample waits, the whole
// pipeline freezes and i_phase.ready drops in the same cycle; nothing is lost.
// Reset clears every stage valid flag and sets wave_mode to square.
module waveform_sample_generator #(
    parameter int DEGREE     = wsg_pkg::DEGREE_DEF,
    parameter int PHASE_BITS = wsg_pkg::PHASE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wsg_pkg::MODE_W-1:0]  i_cfg_wdata,
    wsg_phase_if.sink                   i_phase,
    wsg_sample_if.source                o_sample
);
    logic [wsg_pkg::MODE_W-1:0]    r_wave_mode;
    logic                          w_en;
    logic                          w_out_vld;
    logic [wsg_pkg::SAMPLE_W-1:0]  w_sample;
    wsg_pkg::t_cell_bus            w_chain [0:DEGREE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode <= wsg_pkg::MODE_SQUARE;
        end else if (i_cfg_we) begin
            r_wave_mode <= i_cfg_wdata;
        end
    end

    assign w_en          = !w_out_vld || o_sample.ready;
    assign i_phase.ready = w_en;

    wsg_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_phase.valid),
        .i_phase (i_phase.phase),
        .i_mode  (r_wave_mode),
        .o_bus   (w_chain[0])
    );

    genvar g;
    for (g = 0; g < DEGREE; g++) begin : g_cell
        wsg_cell #(
            .K (DEGREE - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_bus   (w_chain[g]),
            .o_bus   (w_chain[g+1])
        );
    end

    wsg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_bus    (w_chain[DEGREE]),
        .o_vld    (w_out_vld),
        .o_sample (w_sample)
    );

    assign o_sample.valid  = w_out_vld;
    assign o_sample.sample = w_sample;
endmodule
